[hdl/lua_comment_blanker_macros.svh]
// Assertion macros for the comment blanking filter.
`ifndef LUA_COMMENT_BLANKER_MACROS_SVH
`define LUA_COMMENT_BLANKER_MACROS_SVH

`ifndef SYNTHESIS
`define LCB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lua_comment_blanker: same-cycle check failed");
`define LCB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lua_comment_blanker: next-cycle check failed");
`else
`define LCB_ASSERT_IMP(label, ante, cons)
`define LCB_ASSERT_NXT(label, ante, cons)
`endif

`endif

[hdl/lcb_pkg.sv]
// Shared types, character codes and word builders for the comment blanker.
package lcb_pkg;

  localparam int MAX_LEVEL_DEF = 255;

  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  typedef struct packed {
    logic       kind;
    logic [7:0] source_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_status;
    logic       success;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  w0;
    out_word_t  w1;
  } res_bundle_t;

  function automatic out_word_t mk_text(input logic [7:0] b);
    out_word_t w;
    w.text_byte = b;
    w.is_status = 1'b0;
    w.success   = 1'b0;
    w.last      = 1'b0;
    return w;
  endfunction

  function automatic out_word_t mk_status(input logic ok);
    out_word_t w;
    w.text_byte = 8'h00;
    w.is_status = 1'b1;
    w.success   = ok;
    w.last      = 1'b0;
    return w;
  endfunction

endpackage

[hdl/lcb_scanner.sv]
// Scan state registers and per-word result logic of the comment blanker.
module lcb_scanner #(
  parameter int MaxLevel = lcb_pkg::MAX_LEVEL_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  lcb_pkg::in_word_t   in_word,
  output lcb_pkg::res_bundle_t res
);

  localparam int LW = $clog2(MaxLevel + 1);

  localparam logic [2:0] MODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_STRING  = 3'd1;
  localparam logic [2:0] MODE_ESCAPE  = 3'd2;
  localparam logic [2:0] MODE_DASHES  = 3'd3;
  localparam logic [2:0] MODE_BRACKET = 3'd4;
  localparam logic [2:0] MODE_SHORT   = 3'd5;
  localparam logic [2:0] MODE_LONG    = 3'd6;

  logic [2:0]    mode_r, mode_nxt;
  logic          dquote_r, dquote_nxt;
  logic          dash_r, dash_nxt;
  logic [LW-1:0] open_r, open_nxt;
  logic          cand_r, cand_nxt;
  logic [LW-1:0] left_r, left_nxt;
  logic          saw_r, saw_nxt;

  logic [7:0]          c;
  logic                ok;
  lcb_pkg::res_bundle_t r;

  assign c = in_word.source_byte;

  always_comb begin
    mode_nxt   = mode_r;
    dquote_nxt = dquote_r;
    dash_nxt   = dash_r;
    open_nxt   = open_r;
    cand_nxt   = cand_r;
    left_nxt   = left_r;
    saw_nxt    = saw_r;
    ok         = saw_r;
    r.cnt      = 2'd0;
    r.w0       = lcb_pkg::mk_text(lcb_pkg::CH_SPACE);
    r.w1       = lcb_pkg::mk_text(lcb_pkg::CH_SPACE);
    if (in_word.kind) begin
      if (dash_r) begin
        r.w0  = lcb_pkg::mk_text(lcb_pkg::CH_DASH);
        r.cnt = 2'd1;
      end else if (mode_r inside {MODE_DASHES, MODE_BRACKET, MODE_SHORT}) begin
        r.w0  = lcb_pkg::mk_text(lcb_pkg::CH_NL);
        r.cnt = 2'd1;
      end else if (mode_r == MODE_LONG) begin
        ok = 1'b0;
      end
      if (r.cnt == 2'd0) begin
        r.w0  = lcb_pkg::mk_status(ok);
        r.cnt = 2'd1;
      end else begin
        r.w1  = lcb_pkg::mk_status(ok);
        r.cnt = 2'd2;
      end
      mode_nxt   = MODE_NORMAL;
      dquote_nxt = 1'b0;
      dash_nxt   = 1'b0;
      open_nxt   = '0;
      cand_nxt   = 1'b0;
      left_nxt   = '0;
      saw_nxt    = 1'b0;
    end else begin
      saw_nxt = 1'b1;
      r.cnt   = 2'd1;
      case (mode_r)
        MODE_STRING: begin
          if (c == lcb_pkg::CH_BSLASH) begin
            mode_nxt = MODE_ESCAPE;
          end else if (c == (dquote_r ? lcb_pkg::CH_DQUOTE : lcb_pkg::CH_SQUOTE)) begin
            mode_nxt = MODE_NORMAL;
          end
          r.w0 = lcb_pkg::mk_text(c);
        end
        MODE_ESCAPE: begin
          mode_nxt = MODE_STRING;
          r.w0     = lcb_pkg::mk_text(c);
        end
        MODE_DASHES, MODE_BRACKET, MODE_SHORT: begin
          if (mode_r == MODE_DASHES && c == lcb_pkg::CH_LBRACK) begin
            mode_nxt = MODE_BRACKET;
            open_nxt = '0;
          end else if (mode_r == MODE_BRACKET && c == lcb_pkg::CH_EQUAL) begin
            if (open_r < LW'(MaxLevel)) begin
              open_nxt = open_r + LW'(1);
            end
          end else if (mode_r == MODE_BRACKET && c == lcb_pkg::CH_LBRACK) begin
            mode_nxt = MODE_LONG;
            cand_nxt = 1'b0;
            left_nxt = '0;
          end else if (c == lcb_pkg::CH_NL) begin
            mode_nxt = MODE_NORMAL;
            r.w0     = lcb_pkg::mk_text(lcb_pkg::CH_NL);
          end else begin
            mode_nxt = MODE_SHORT;
          end
        end
        MODE_LONG: begin
          if (c == lcb_pkg::CH_EQUAL) begin
            if (cand_r) begin
              if (left_r == '0) begin
                cand_nxt = 1'b0;
              end else begin
                left_nxt = left_r - LW'(1);
              end
            end
          end else if (c == lcb_pkg::CH_RBRACK) begin
            if (cand_r && left_r == '0) begin
              mode_nxt = MODE_NORMAL;
              cand_nxt = 1'b0;
            end else begin
              cand_nxt = 1'b1;
              left_nxt = open_r;
            end
          end else begin
            cand_nxt = 1'b0;
          end
          if (c == lcb_pkg::CH_NL) begin
            r.w0 = lcb_pkg::mk_text(lcb_pkg::CH_NL);
          end
        end
        default: begin
          mode_nxt = MODE_NORMAL;
          if (dash_r) begin
            dash_nxt = 1'b0;
            r.cnt    = 2'd2;
            if (c == lcb_pkg::CH_DASH) begin
              mode_nxt = MODE_DASHES;
            end else begin
              r.w0 = lcb_pkg::mk_text(lcb_pkg::CH_DASH);
              r.w1 = lcb_pkg::mk_text(c);
              if (c == lcb_pkg::CH_SQUOTE || c == lcb_pkg::CH_DQUOTE) begin
                mode_nxt   = MODE_STRING;
                dquote_nxt = (c == lcb_pkg::CH_DQUOTE);
              end
            end
          end else if (c == lcb_pkg::CH_DASH) begin
            dash_nxt = 1'b1;
            r.cnt    = 2'd0;
          end else begin
            r.w0 = lcb_pkg::mk_text(c);
            if (c == lcb_pkg::CH_SQUOTE || c == lcb_pkg::CH_DQUOTE) begin
              mode_nxt   = MODE_STRING;
              dquote_nxt = (c == lcb_pkg::CH_DQUOTE);
            end
          end
        end
      endcase
    end
    if (r.cnt == 2'd1) begin
      r.w0.last = 1'b1;
    end
    if (r.cnt == 2'd2) begin
      r.w1.last = 1'b1;
    end
  end

  assign res = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NORMAL;
      dquote_r <= 1'b0;
      dash_r   <= 1'b0;
      open_r   <= '0;
      cand_r   <= 1'b0;
      left_r   <= '0;
      saw_r    <= 1'b0;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      dquote_r <= dquote_nxt;
      dash_r   <= dash_nxt;
      open_r   <= open_nxt;
      cand_r   <= cand_nxt;
      left_r   <= left_nxt;
      saw_r    <= saw_nxt;
    end
  end

endmodule

[hdl/lcb_out_buf.sv]
// Two-word result register: head drives the output, second slot holds an overflow word.
module lcb_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lcb_pkg::res_bundle_t res,
  output logic                 can_push,
  output logic                 spare_busy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lcb_pkg::out_word_t   out_data
);

  logic               v0_r, v0_nxt;
  logic               v1_r, v1_nxt;
  lcb_pkg::out_word_t d0_r, d0_nxt;
  lcb_pkg::out_word_t d1_r, d1_nxt;
  logic               pop;

  assign pop      = v0_r && out_ready;
  assign can_push = !v1_r && (!v0_r || out_ready);

  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    d0_nxt = d0_r;
    d1_nxt = d1_r;
    if (push && res.cnt != 2'd0) begin
      v0_nxt = 1'b1;
      d0_nxt = res.w0;
      v1_nxt = (res.cnt == 2'd2);
      d1_nxt = res.w1;
    end else if (pop) begin
      v0_nxt = v1_r;
      d0_nxt = d1_r;
      v1_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

  assign out_valid  = v0_r;
  assign out_data   = d0_r;
  assign spare_busy = v1_r;

endmodule

[hdl/lua_comment_blanker.sv]
// Top level of the Lua comment blanking filter.
// Usage:
//   in_data carries one word per handshake: kind 0 is a source byte, kind 1 ends the text.
//   out_data carries text bytes with comments turned into spaces (newlines kept),
//   and after each end word a status word (is_status 1, success 0 on empty text or
//   an open long comment). last marks the final word caused by one input word.
//   A word's first result is registered into the head of the result register at the edge that accepts it.
//   Throughput: one input word per cycle while each gives at most one result and the receiver takes each word.
//   A word that gives two results fills the second slot of the result register;
//   in_ready stays low until that word moves up to the head.
//   A held dash gives no result until the next word decides it.
//   in_ready follows out_ready combinationally: a full head register frees when
//   the receiver takes its word, so a stalled receiver holds in_ready low.
//   Reset (rst_n low, synchronous) empties the result register and returns the
//   scanner to plain code; each end word also returns it there.
module lua_comment_blanker #(
  parameter int MAX_LEVEL = lcb_pkg::MAX_LEVEL_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lcb_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lcb_pkg::out_word_t out_data
);

`include "lua_comment_blanker_macros.svh"

  logic                 acc;
  logic                 can_push;
  logic                 spare_busy;
  lcb_pkg::res_bundle_t res;

  assign in_ready = can_push;
  assign acc      = in_valid && can_push;

  lcb_scanner #(
    .MaxLevel(MAX_LEVEL)
  ) u_scanner (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_word (in_data),
    .res     (res)
  );

  lcb_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (acc),
    .res        (res),
    .can_push   (can_push),
    .spare_busy (spare_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  `LCB_ASSERT_NXT(a_end_gives_word, acc && in_data.kind, out_valid)
  `LCB_ASSERT_IMP(a_status_is_last, out_valid && out_data.is_status, out_data.last)
  `LCB_ASSERT_IMP(a_status_no_text, out_valid && out_data.is_status, out_data.text_byte == 8'h00)
  `LCB_ASSERT_IMP(a_spare_blocks_in, spare_busy, !in_ready && out_valid)

endmodule

[tb/tb_lua_comment_blanker.sv]
// Self-checking testbench for lua_comment_blanker with a word-level scoreboard.
`timescale 1ns / 100ps

typedef enum logic [2:0] {
  SCAN_CODE, SCAN_STRING, SCAN_ESCAPE, SCAN_DASHES, SCAN_OPENER, SCAN_SHORT, SCAN_LONG
} scan_mode_t;

class blank_tracker;
  lcb_pkg::out_word_t blanked_q[$];
  scan_mode_t mode;
  logic       dq_open;
  logic       dash_held;
  logic [7:0] open_lvl;
  logic       close_cand;
  logic [7:0] close_left;
  logic       seen_byte;
  int errors;
  int words_in;
  int words_out;
  int texts;
  int bad_texts;
  int longs;

  function new();
    clear_state();
  endfunction

  function void clear_state();
    mode       = SCAN_CODE;
    dq_open    = 1'b0;
    dash_held  = 1'b0;
    open_lvl   = 8'd0;
    close_cand = 1'b0;
    close_left = 8'd0;
    seen_byte  = 1'b0;
  endfunction

  task report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  function void emit(logic [7:0] b, logic st, logic ok);
    lcb_pkg::out_word_t w;
    w.text_byte = b;
    w.is_status = st;
    w.success   = ok;
    w.last      = 1'b0;
    blanked_q = {blanked_q, w};
  endfunction

  function void code_byte(logic [7:0] c);
    if (c == lcb_pkg::CH_SQUOTE || c == lcb_pkg::CH_DQUOTE) begin
      mode    = SCAN_STRING;
      dq_open = (c == lcb_pkg::CH_DQUOTE);
    end
    emit(c, 1'b0, 1'b0);
  endfunction

  function void short_byte(logic [7:0] c);
    if (c == lcb_pkg::CH_NL) begin
      mode = SCAN_CODE;
      emit(lcb_pkg::CH_NL, 1'b0, 1'b0);
    end else begin
      mode = SCAN_SHORT;
      emit(lcb_pkg::CH_SPACE, 1'b0, 1'b0);
    end
  endfunction

  function void predict_blanking(lcb_pkg::in_word_t w);
    logic [7:0] c;
    logic       ok;
    int         start;
    c = w.source_byte;
    start = blanked_q.size();
    words_in++;
    if (w.kind) begin
      ok = seen_byte;
      texts++;
      if (dash_held) emit(lcb_pkg::CH_DASH, 1'b0, 1'b0);
      else if (mode == SCAN_DASHES || mode == SCAN_OPENER || mode == SCAN_SHORT)
        emit(lcb_pkg::CH_NL, 1'b0, 1'b0);
      else if (mode == SCAN_LONG) ok = 1'b0;
      if (!ok) bad_texts++;
      emit(8'h00, 1'b1, ok);
      clear_state();
    end else begin
      seen_byte = 1'b1;
      case (mode)
        SCAN_STRING: begin
          if (c == lcb_pkg::CH_BSLASH) mode = SCAN_ESCAPE;
          else if (c == (dq_open ? lcb_pkg::CH_DQUOTE : lcb_pkg::CH_SQUOTE)) mode = SCAN_CODE;
          emit(c, 1'b0, 1'b0);
        end
        SCAN_ESCAPE: begin
          mode = SCAN_STRING;
          emit(c, 1'b0, 1'b0);
        end
        SCAN_DASHES: begin
          if (c == lcb_pkg::CH_LBRACK) begin
            mode = SCAN_OPENER;
            open_lvl = 8'd0;
            emit(lcb_pkg::CH_SPACE, 1'b0, 1'b0);
          end else short_byte(c);
        end
        SCAN_OPENER: begin
          if (c == lcb_pkg::CH_EQUAL) begin
            if (open_lvl < lcb_pkg::MAX_LEVEL_DEF) open_lvl++;
            emit(lcb_pkg::CH_SPACE, 1'b0, 1'b0);
          end else if (c == lcb_pkg::CH_LBRACK) begin
            mode = SCAN_LONG;
            close_cand = 1'b0;
            close_left = 8'd0;
            longs++;
            emit(lcb_pkg::CH_SPACE, 1'b0, 1'b0);
          end else short_byte(c);
        end
        SCAN_SHORT: short_byte(c);
        SCAN_LONG: begin
          if (c == lcb_pkg::CH_EQUAL) begin
            if (close_cand) begin
              if (close_left == 8'd0) close_cand = 1'b0;
              else close_left--;
            end
          end else if (c == lcb_pkg::CH_RBRACK) begin
            if (close_cand && close_left == 8'd0) begin
              mode = SCAN_CODE;
              close_cand = 1'b0;
            end else begin
              close_cand = 1'b1;
              close_left = open_lvl;
            end
          end else close_cand = 1'b0;
          emit((c == lcb_pkg::CH_NL) ? lcb_pkg::CH_NL : lcb_pkg::CH_SPACE, 1'b0, 1'b0);
        end
        default: begin
          mode = SCAN_CODE;
          if (dash_held) begin
            dash_held = 1'b0;
            if (c == lcb_pkg::CH_DASH) begin
              mode = SCAN_DASHES;
              emit(lcb_pkg::CH_SPACE, 1'b0, 1'b0);
              emit(lcb_pkg::CH_SPACE, 1'b0, 1'b0);
            end else begin
              emit(lcb_pkg::CH_DASH, 1'b0, 1'b0);
              code_byte(c);
            end
          end else if (c == lcb_pkg::CH_DASH) dash_held = 1'b1;
          else code_byte(c);
        end
      endcase
    end
    if (blanked_q.size() > start) blanked_q[blanked_q.size() - 1].last = 1'b1;
  endfunction

  task check_blanked(lcb_pkg::out_word_t got);
    lcb_pkg::out_word_t want;
    words_out++;
    if (blanked_q.size() == 0) begin
      report_mismatch($sformatf("word %h with nothing expected", got));
      return;
    end
    want = blanked_q.pop_front();
    if (got.text_byte !== want.text_byte)
      report_mismatch($sformatf("text_byte %h, want %h", got.text_byte, want.text_byte));
    if (got.is_status !== want.is_status)
      report_mismatch($sformatf("is_status %b, want %b", got.is_status, want.is_status));
    if (got.success !== want.success)
      report_mismatch($sformatf("success %b, want %b", got.success, want.success));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %b, want %b", got.last, want.last));
  endtask
endclass

module tb_lua_comment_blanker;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lcb_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lcb_pkg::out_word_t out_data;

  blank_tracker sb = new();
  lcb_pkg::in_word_t src_q[$];
  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_starts = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet = 0;

  lua_comment_blanker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_starts != hold_seen) begin
      hold_seen = hold_starts;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      quiet++;
      if (out_valid && out_ready) begin
        sb.check_blanked(out_data);
        quiet = 0;
      end
      if (in_valid && in_ready) begin
        sb.predict_blanking(in_data);
        quiet = 0;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic void push_byte(logic [7:0] b);
    lcb_pkg::in_word_t w;
    w.kind = 1'b0;
    w.source_byte = b;
    src_q = {src_q, w};
  endfunction

  function automatic void push_end();
    lcb_pkg::in_word_t w;
    w.kind = 1'b1;
    w.source_byte = 8'($urandom_range(255));
    src_q = {src_q, w};
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  function automatic void gen_random(int target);
    int start;
    int r;
    int n;
    int m;
    logic [7:0] b;
    start = src_q.size();
    while (src_q.size() - start < target) begin
      r = $urandom_range(99);
      if (r < 25) begin
        repeat ($urandom_range(6, 1)) begin
          if ($urandom_range(1)) push_byte(pick("ab -=[]'\"\\\n"));
          else push_byte(8'($urandom_range(255)));
        end
      end else if (r < 40) begin
        push_str("--");
        repeat ($urandom_range(8)) begin
          do b = 8'($urandom_range(255)); while (b == lcb_pkg::CH_NL);
          push_byte(b);
        end
        if ($urandom_range(7) != 0) push_byte(lcb_pkg::CH_NL);
      end else if (r < 58) begin
        n = ($urandom_range(39) == 0) ? $urandom_range(262, 250) : $urandom_range(3);
        m = (n > lcb_pkg::MAX_LEVEL_DEF) ? lcb_pkg::MAX_LEVEL_DEF : n;
        push_str("--[");
        repeat (n) push_byte(lcb_pkg::CH_EQUAL);
        push_byte(lcb_pkg::CH_LBRACK);
        repeat ($urandom_range(10)) push_byte(pick("]]==x \n"));
        if ($urandom_range(3) == 0) begin
          push_byte(lcb_pkg::CH_RBRACK);
          repeat (m + 1) push_byte(lcb_pkg::CH_EQUAL);
          push_byte(lcb_pkg::CH_RBRACK);
        end
        if ($urandom_range(7) != 0) begin
          push_byte(lcb_pkg::CH_RBRACK);
          repeat (m) push_byte(lcb_pkg::CH_EQUAL);
          push_byte(lcb_pkg::CH_RBRACK);
        end
      end else if (r < 72) begin
        b = $urandom_range(1) ? lcb_pkg::CH_DQUOTE : lcb_pkg::CH_SQUOTE;
        push_byte(b);
        repeat ($urandom_range(8)) begin
          if ($urandom_range(3) == 0) begin
            push_byte(lcb_pkg::CH_BSLASH);
            push_byte(8'($urandom_range(255)));
          end else push_byte(pick("ab-=[] \"'"));
        end
        push_byte(b);
      end else if (r < 82) begin
        push_byte(lcb_pkg::CH_DASH);
        do b = 8'($urandom_range(255)); while (b == lcb_pkg::CH_DASH);
        push_byte(b);
      end else if (r < 88) begin
        push_str("--[");
        repeat ($urandom_range(3)) push_byte(lcb_pkg::CH_EQUAL);
        do b = 8'($urandom_range(255)); while (b == lcb_pkg::CH_EQUAL || b == lcb_pkg::CH_LBRACK);
        push_byte(b);
      end else begin
        push_end();
        if ($urandom_range(4) == 0) push_end();
      end
    end
  endfunction

  task automatic send_word(lcb_pkg::in_word_t w);
    while ($urandom_range(99) < snd_idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_queue();
    while (src_q.size() > 0) send_word(src_q.pop_front());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    snd_idle = 13;
    rcv_idle = 51;
    push_end();
    push_byte(8'h00);
    push_byte(lcb_pkg::CH_DASH);
    push_byte(8'hFF);
    push_byte(lcb_pkg::CH_DASH);
    push_end();
    push_str("--[=x");
    push_end();
    push_str("--[[]]\"\\\"");
    push_end();
    push_str("--[[");
    push_end();
    drain_queue();

    gen_random(410);
    drain_queue();

    snd_idle = 51;
    rcv_idle = 13;
    gen_random(410);
    drain_queue();

    snd_idle = 0;
    rcv_idle = 0;
    hold_starts++;
    gen_random(410);
    push_end();
    drain_queue();

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.blanked_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d input words over %0d texts (%0d with failing status),",
             sb.words_in, sb.texts, sb.bad_texts);
    $display("%0d result words checked, %0d long comments opened.", sb.words_out, sb.longs);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
